// ----- rtl/led_cube_frame_buffer_scanner_top_macros.svh -----
// Assertion macros for the LED cube frame buffer scanner.
`ifndef LED_CUBE_FRAME_BUFFER_SCANNER_TOP_MACROS_SVH
`define LED_CUBE_FRAME_BUFFER_SCANNER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCFB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcfb check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LCFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcfb check failed");

`endif

// ----- rtl/lcfb_pkg.sv -----
// Shared types and constants for the LED cube frame buffer scanner.
`timescale 1ns / 1ps
package lcfb_pkg;

  localparam int SIDE_DEF = 5;
  localparam int POS_W    = 3;
  localparam int SUM_W    = POS_W + 1;
  localparam int OP_W     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_FILL      = 4'd0,
    OP_SET_VOXEL = 4'd1,
    OP_READ      = 4'd2,
    OP_LINE_X    = 4'd3,
    OP_LINE_Z    = 4'd4,
    OP_LINE_Y    = 4'd5,
    OP_PLANE_Y   = 4'd6,
    OP_PLANE_X   = 4'd7,
    OP_PLANE_Z   = 4'd8,
    OP_SHIFT_Z   = 4'd9,
    OP_SCAN      = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Decoded command as seen by the level word update unit.
  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             value;
    logic [POS_W-1:0] dst;
    logic             dst_ok;
  } cmd_t;

endpackage

// ----- rtl/led_cube_frame_buffer_scanner_top.sv -----
// Top level of the LED cube frame buffer scanner: sequencer and drive register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   in_      | in_valid / in_stall  | operation, x/y/z_pos, value, amount, dir
//   out_     | out_valid / out_stall| pixel_value, level_enable, column_drive
//
// Every command walks all levels in the sequencer, one read-modify-write of a
// level word per cycle through the shared update unit, then the done state
// loads the output register once that register is free.
// Reset is synchronous and clears the frame store, active level and drive.
// A finished word waits in the output register while a new command is taken;
// that command then holds in its last state until the register frees up.
`timescale 1ns / 1ps
`include "led_cube_frame_buffer_scanner_top_macros.svh"
module led_cube_frame_buffer_scanner_top import lcfb_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  localparam int WW  = SIDE * SIDE,
  localparam int LW  = $clog2(SIDE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [POS_W-1:0] in_x_pos,
  input  logic [POS_W-1:0] in_y_pos,
  input  logic [POS_W-1:0] in_z_pos,
  input  logic             in_value,
  input  logic [POS_W-1:0] in_amount,
  input  logic             in_direction,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pixel_value,
  output logic [SIDE-1:0]  out_level_enable,
  output logic [WW-1:0]    out_column_drive
);

  state_t        state_r;
  cmd_t          cmd_r;
  cmd_t          cmd_in;
  logic [LW-1:0] lvl_r;
  logic [LW-1:0] active_r;
  logic [LW-1:0] next_lvl_r;
  logic [LW-1:0] next_lvl;
  logic          pix_r;
  logic [WW-1:0] cap_r;
  logic          out_valid_r;
  logic          out_pix_r;
  logic [SIDE-1:0] out_level_r;
  logic [WW-1:0] out_col_r;
  logic [WW-1:0] rdata;
  logic [WW-1:0] wdata;
  logic          pix_hit;
  logic [SUM_W-1:0] dst_sum;
  logic          src_ok;
  logic          accept;
  logic          out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Decode the incoming word, including where a shifted plane lands.
  always_comb begin
    dst_sum       = SUM_W'(in_z_pos) + SUM_W'(in_amount);
    src_ok        = (SUM_W'(in_z_pos) < SUM_W'(SIDE));
    cmd_in.op     = op_t'(in_operation);
    cmd_in.x      = in_x_pos;
    cmd_in.y      = in_y_pos;
    cmd_in.z      = in_z_pos;
    cmd_in.value  = in_value;
    if (in_direction) begin
      cmd_in.dst_ok = src_ok && (in_amount <= in_z_pos);
      cmd_in.dst    = in_z_pos - in_amount;
    end else begin
      cmd_in.dst_ok = src_ok && (dst_sum < SUM_W'(SIDE));
      cmd_in.dst    = dst_sum[POS_W-1:0];
    end
  end

  assign next_lvl = (active_r == LW'(SIDE - 1)) ? '0 : active_r + LW'(1);

  lcfb_store #(.SIDE(SIDE)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (lvl_r),
    .we    (state_r == ST_WALK),
    .wdata (wdata),
    .rdata (rdata)
  );

  lcfb_word_unit #(.SIDE(SIDE)) u_word_unit (
    .cmd      (cmd_r),
    .lvl      (lvl_r),
    .word_in  (rdata),
    .word_out (wdata),
    .pix_hit  (pix_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      out_level_r <= '0;
      out_col_r   <= '0;
      out_pix_r   <= 1'b0;
      lvl_r       <= '0;
    end else begin
      // In the done state the output register is reloaded below instead.
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r      <= cmd_in;
            lvl_r      <= '0;
            pix_r      <= 1'b0;
            next_lvl_r <= next_lvl;
            state_r    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (pix_hit) begin
            pix_r <= 1'b1;
          end
          // The scan latches the new level word as the walk passes it.
          if (lvl_r == next_lvl_r) begin
            cap_r <= rdata;
          end
          if (lvl_r == LW'(SIDE - 1)) begin
            state_r <= ST_DONE;
          end else begin
            lvl_r <= lvl_r + LW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= pix_r;
            if (cmd_r.op == OP_SCAN) begin
              active_r    <= next_lvl_r;
              out_level_r <= SIDE'(1) << next_lvl_r;
              out_col_r   <= cap_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pix_r;
  assign out_level_enable = out_level_r;
  assign out_column_drive = out_col_r;

  `LCFB_ASSERT_SAME(a_level_onehot, 1'b1, $onehot0(out_level_enable))
  `LCFB_ASSERT_NEXT(a_accept_walk, accept, (state_r == ST_WALK) && (lvl_r == '0))
  `LCFB_ASSERT_SAME(a_valid_from_done, $rose(out_valid), $past(state_r == ST_DONE))
  `LCFB_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
                    out_valid && $stable(out_column_drive) && $stable(out_pixel_value))

endmodule

// ----- rtl/lcfb_store.sv -----
// Frame store: one word per cube level, one read and one write port.
`timescale 1ns / 1ps
module lcfb_store import lcfb_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  localparam int WW  = SIDE * SIDE,
  localparam int LW  = $clog2(SIDE)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [LW-1:0] addr,
  input  logic          we,
  input  logic [WW-1:0] wdata,
  output logic [WW-1:0] rdata
);

  logic [WW-1:0] level_r [SIDE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE; i++) begin
        level_r[i] <= '0;
      end
    end else if (we) begin
      level_r[addr] <= wdata;
    end
  end

  assign rdata = level_r[addr];

endmodule

// ----- rtl/lcfb_word_unit.sv -----
// Shared update unit: applies one command to one level word.
`timescale 1ns / 1ps
module lcfb_word_unit import lcfb_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  localparam int WW  = SIDE * SIDE,
  localparam int LW  = $clog2(SIDE)
) (
  input  cmd_t          cmd,
  input  logic [LW-1:0] lvl,
  input  logic [WW-1:0] word_in,
  output logic [WW-1:0] word_out,
  output logic          pix_hit
);

  logic [WW-1:0] x_mask;
  logic [WW-1:0] z_mask;
  logic [WW-1:0] dst_mask;
  logic [WW-1:0] wr_mask;
  logic [WW-1:0] moved;
  logic [WW-1:0] shifted;
  logic [POS_W-1:0] z_step;
  logic          lvl_hit;

  // A coordinate outside the cube matches no position, so its mask is empty.
  always_comb begin
    for (int xi = 0; xi < SIDE; xi++) begin
      for (int zi = 0; zi < SIDE; zi++) begin
        x_mask[xi*SIDE+zi]   = (cmd.x == POS_W'(xi));
        z_mask[xi*SIDE+zi]   = (cmd.z == POS_W'(zi));
        dst_mask[xi*SIDE+zi] = (cmd.dst == POS_W'(zi));
      end
    end
  end

  assign lvl_hit = (cmd.y == POS_W'(lvl));

  always_comb begin
    unique case (cmd.op)
      OP_FILL:      wr_mask = '1;
      OP_SET_VOXEL: wr_mask = lvl_hit ? (x_mask & z_mask) : '0;
      OP_LINE_X:    wr_mask = lvl_hit ? z_mask : '0;
      OP_LINE_Z:    wr_mask = lvl_hit ? x_mask : '0;
      OP_LINE_Y:    wr_mask = x_mask & z_mask;
      OP_PLANE_Y:   wr_mask = lvl_hit ? '1 : '0;
      OP_PLANE_X:   wr_mask = x_mask;
      OP_PLANE_Z:   wr_mask = z_mask;
      default:      wr_mask = '0;
    endcase
  end

  // Shift: the source plane bits move along z within each row, then the
  // source plane is cleared, also for a shift by zero.
  always_comb begin
    if (cmd.dst >= cmd.z) begin
      z_step = cmd.dst - cmd.z;
      moved  = (word_in & z_mask) << z_step;
    end else begin
      z_step = cmd.z - cmd.dst;
      moved  = (word_in & z_mask) >> z_step;
    end
    shifted = cmd.dst_ok ? ((word_in & ~dst_mask) | moved) : word_in;
    shifted = shifted & ~z_mask;
  end

  always_comb begin
    if (cmd.op == OP_SHIFT_Z) begin
      word_out = shifted;
    end else begin
      word_out = (word_in & ~wr_mask) | (cmd.value ? wr_mask : '0);
    end
  end

  assign pix_hit = (cmd.op == OP_READ) && lvl_hit && (|(word_in & x_mask & z_mask));

endmodule
